// ===== rtl/rmwf_pkg.sv =====
// package for the rgb median window filter
// pixel and column types, lane control struct and small compare helpers
// no dependencies
`timescale 1ns / 1ps

package rmwf_pkg;

  // window geometry, radius fixed at one
  localparam int Radius = 1;
  localparam int WinDim = 2 * Radius + 1;
  localparam int PixW   = 8;

  typedef logic [PixW-1:0] pix_t;

  // one window column sorted ascending
  typedef struct packed {
    pix_t lo;
    pix_t mi;
    pix_t hi;
  } col_t;

  // control from the top level to each lane
  typedef struct packed {
    logic accept;  // a column transfer happens this cycle
    logic en;      // pipeline stages may advance
  } lane_ctrl_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  // median of three values
  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // three-element sort
  function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col_t r;
    r.lo = min3(a, b, c);
    r.mi = med3(a, b, c);
    r.hi = max3(a, b, c);
    return r;
  endfunction

endpackage

// ===== rtl/rmwf_lane.sv =====
// one color lane: sorted column window and two-level median network
// uses rmwf_pkg for pixel types and compare helpers
`timescale 1ns / 1ps

module rmwf_lane (
  input  logic                   clk_i,
  input  rmwf_pkg::lane_ctrl_t   ctrl_i,
  input  rmwf_pkg::pix_t         top_i,
  input  rmwf_pkg::pix_t         mid_i,
  input  rmwf_pkg::pix_t         low_i,
  output rmwf_pkg::pix_t         median_o
);
  import rmwf_pkg::*;

  // window of sorted columns, col2 newest
  col_t col0_q, col1_q, col2_q;
  col_t col_new;

  // second level: max of lows, median of mids, min of highs
  pix_t max_lo_q, med_mi_q, min_hi_q;
  pix_t max_lo_d, med_mi_d, min_hi_d;

  // sort the incoming column before it enters the window
  assign col_new = sort3(top_i, mid_i, low_i);

  // slide the window on every column transfer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      col0_q <= col1_q;
      col1_q <= col2_q;
      col2_q <= col_new;
    end
  end

  // combine the three sorted columns
  always_comb begin
    max_lo_d = max3(col0_q.lo, col1_q.lo, col2_q.lo);
    med_mi_d = med3(col0_q.mi, col1_q.mi, col2_q.mi);
    min_hi_d = min3(col0_q.hi, col1_q.hi, col2_q.hi);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      max_lo_q <= max_lo_d;
      med_mi_q <= med_mi_d;
      min_hi_q <= min_hi_d;
    end
  end

  // final median of the three candidates
  assign median_o = med3(max_lo_q, med_mi_q, min_hi_q);

endmodule

// ===== rtl/rmwf_merge.sv =====
// merging stage: gathers the lane medians into the output register and skid stage
// uses rmwf_pkg for pixel types
`timescale 1ns / 1ps

module rmwf_merge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_valid_i,
  input  rmwf_pkg::pix_t  red_i,
  input  rmwf_pkg::pix_t  green_i,
  input  rmwf_pkg::pix_t  blue_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output rmwf_pkg::pix_t  median_red_o,
  output rmwf_pkg::pix_t  median_green_o,
  output rmwf_pkg::pix_t  median_blue_o,
  output logic            skid_full_o
);
  import rmwf_pkg::*;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  rgb_t out_q, out_d, skid_q, skid_d, res;
  logic out_take;

  assign res      = '{r: red_i, g: green_i, b: blue_i};
  assign out_take = out_valid_q && !out_stall_i;

  // output register with one skid entry behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_d = res_valid_i;
      out_d       = res;
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign median_red_o   = out_q.r;
  assign median_green_o = out_q.g;
  assign median_blue_o  = out_q.b;
  assign skid_full_o    = skid_valid_q;

endmodule

// ===== rtl/rgb_median_window_filter_core.sv =====
// channel   | handshake               | payload
// input     | in_valid_i / in_stall_o | row_start_i, {top,mid,low}_{red,green,blue}_i
// output    | out_valid_o/ out_stall_i| median_red_o, median_green_o, median_blue_o
//
// one column transfer per cycle while in_stall_o is low; a column is sorted into the window, then its
// result is registered at the column combine and lands, as the final median, in the output register.
// each of the three lanes, one per color, is a two-level compare network per item.
// reset clears the column count, pipeline valid bits, output and skid flags;
// window contents stay undefined until the row fills.
// in_stall_o rises only when the skid entry is occupied, then the pipeline holds.
// depends on rmwf_pkg, rmwf_lane and rmwf_merge
`timescale 1ns / 1ps

module rgb_median_window_filter_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            row_start_i,
  input  rmwf_pkg::pix_t  top_red_i,
  input  rmwf_pkg::pix_t  mid_red_i,
  input  rmwf_pkg::pix_t  low_red_i,
  input  rmwf_pkg::pix_t  top_green_i,
  input  rmwf_pkg::pix_t  mid_green_i,
  input  rmwf_pkg::pix_t  low_green_i,
  input  rmwf_pkg::pix_t  top_blue_i,
  input  rmwf_pkg::pix_t  mid_blue_i,
  input  rmwf_pkg::pix_t  low_blue_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rmwf_pkg::pix_t  median_red_o,
  output rmwf_pkg::pix_t  median_green_o,
  output rmwf_pkg::pix_t  median_blue_o
);
  import rmwf_pkg::*;

  localparam logic [1:0] ColsFull = 2'(WinDim);

  logic       skid_full;
  logic       accept;
  lane_ctrl_t ctrl;
  logic [1:0] cols_q, cols_d, cols_base;
  logic       va_q, vb_q;
  pix_t       med_r, med_g, med_b;

  assign in_stall_o  = skid_full;
  assign accept      = in_valid_i && !in_stall_o;
  assign ctrl.accept = accept;
  assign ctrl.en     = !skid_full;

  // columns since row start, saturating at a full window
  always_comb begin
    cols_base = row_start_i ? 2'd0 : cols_q;
    cols_d    = (cols_base < ColsFull) ? cols_base + 2'd1 : cols_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 2'd0;
    end else if (accept) begin
      cols_q <= cols_d;
    end
  end

  // valid bits following the lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (ctrl.en) begin
      va_q <= accept && (cols_d == ColsFull);
      vb_q <= va_q;
    end
  end

  // one lane per color
  rmwf_lane u_lane_red (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .top_i    (top_red_i),
    .mid_i    (mid_red_i),
    .low_i    (low_red_i),
    .median_o (med_r)
  );

  rmwf_lane u_lane_green (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .top_i    (top_green_i),
    .mid_i    (mid_green_i),
    .low_i    (low_green_i),
    .median_o (med_g)
  );

  rmwf_lane u_lane_blue (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .top_i    (top_blue_i),
    .mid_i    (mid_blue_i),
    .low_i    (low_blue_i),
    .median_o (med_b)
  );

  // merge lane results into the output register
  rmwf_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (vb_q && ctrl.en),
    .red_i          (med_r),
    .green_i        (med_g),
    .blue_i         (med_b),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .median_red_o   (median_red_o),
    .median_green_o (median_green_o),
    .median_blue_o  (median_blue_o),
    .skid_full_o    (skid_full)
  );

endmodule

// ===== rtl/rmwf_checker.sv =====
// port-level checker for the rgb median window filter core, bound to the top level
// uses rmwf_pkg for pixel types
`timescale 1ns / 1ps

module rmwf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input rmwf_pkg::pix_t  median_red_o,
  input rmwf_pkg::pix_t  median_green_o,
  input rmwf_pkg::pix_t  median_blue_o
);
  import rmwf_pkg::*;

  // input stall only appears after a stalled output transfer
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without a stalled output");

  // a held skid entry means the output register is occupied
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output is empty");

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_red_o)
      && $stable(median_green_o) && $stable(median_blue_o))
    else $error("stalled result changed");

endmodule

bind rgb_median_window_filter_core rmwf_checker u_rmwf_checker (.*);
